// File: design/fm_synth_register_and_timer_block_macros.svh
// Assertion macros for the FM register and timer block checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef FM_SYNTH_REGISTER_AND_TIMER_BLOCK_MACROS_SVH
`define FM_SYNTH_REGISTER_AND_TIMER_BLOCK_MACROS_SVH

// same-cycle implication
`define FMS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define FMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: design/fmsrt_pkg.sv
// Shared types and constants of the FM register and timer block.
// No dependencies.
`timescale 1ns / 1ps
package fmsrt_pkg;

    localparam int unsigned C_TIMER_A_PERIOD = 144;
    localparam int unsigned C_TIMER_B_PERIOD = 2304;
    localparam int unsigned CHANNELS         = 6;
    localparam int unsigned OPERATORS        = 4;

    localparam int unsigned TUSER_W = 4;
    localparam int unsigned TDATA_W = 32;
    localparam int unsigned DIV_W   = 17;
    localparam int unsigned CNT_W   = 5;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLOCK = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] REG_TA_HI   = 8'h24;
    localparam logic [7:0] REG_TA_LO   = 8'h25;
    localparam logic [7:0] REG_TB      = 8'h26;
    localparam logic [7:0] REG_TCTRL   = 8'h27;
    localparam logic [7:0] REG_KEY     = 8'h28;
    localparam logic [7:0] REG_OP_BASE = 8'h30;
    localparam logic [7:0] REG_CH_BASE = 8'hA0;
    localparam logic [3:0] GRP_TL      = 4'h4;
    localparam logic [7:0] REG_FNUM_LO = 8'hA0;
    localparam logic [7:0] REG_FNUM_HI = 8'hA4;
    localparam logic [7:0] REG_ALG     = 8'hB0;
    localparam logic [1:0] CH_NONE     = 2'd3;

    localparam logic [1:0] C_SLOT [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

    typedef struct packed {
        logic idle;
        logic accept;
        logic sel;
        logic start_pre;
        logic step;
        logic end_pre;
        logic end_mod;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_clock;
        logic div_done;
        logic need_mod;
        logic out_free;
    } t_sts;

endpackage

// File: design/fmsrt_ctrl.sv
// Sequencer of the FM register and timer block: on a clock item, walks both timers through the divider.
// Depends on fmsrt_pkg.
`timescale 1ns / 1ps
module fmsrt_ctrl import fmsrt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LD   = 3'd1;
    localparam logic [2:0] S_DIVP = 3'd2;
    localparam logic [2:0] S_ENDP = 3'd3;
    localparam logic [2:0] S_DIVM = 3'd4;
    localparam logic [2:0] S_ENDM = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE: begin
                o_cmd.idle   = 1'b1;
                o_cmd.accept = i_valid;
                n_sel        = 1'b0;
                if (i_valid) begin
                    n_state = i_sts.is_clock ? S_LD : S_DONE;
                end
            end
            S_LD: begin
                o_cmd.start_pre = 1'b1;
                n_state         = S_DIVP;
            end
            S_DIVP: begin
                if (i_sts.div_done) begin
                    n_state = S_ENDP;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_ENDP: begin
                o_cmd.end_pre = 1'b1;
                if (i_sts.need_mod) begin
                    n_state = S_DIVM;
                end else if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_LD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIVM: begin
                if (i_sts.div_done) begin
                    n_state = S_ENDM;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_ENDM: begin
                o_cmd.end_mod = 1'b1;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_LD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

// File: design/fmsrt_dp.sv
// Datapath of the FM register and timer block: register file, timers, prescaler reciprocal
// multiply, shared wrap divider, output register. Depends on fmsrt_pkg.
`timescale 1ns / 1ps
module fmsrt_dp import fmsrt_pkg::*; #(
    parameter int unsigned TIMER_A_PERIOD = C_TIMER_A_PERIOD,
    parameter int unsigned TIMER_B_PERIOD = C_TIMER_B_PERIOD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [TUSER_W-1:0] i_tuser,
    input  logic [TDATA_W-1:0] i_tdata,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [TDATA_W-1:0] o_m_data
);
    function automatic logic [DIV_W:0] f_recip(input int unsigned d, input int unsigned sh);
        logic [63:0] p;
        p = 64'd1 << sh;
        return (DIV_W+1)'((p + 64'(d) - 64'd1) / 64'(d));
    endfunction

    localparam int unsigned    A_SH  = DIV_W + $clog2(TIMER_A_PERIOD);
    localparam int unsigned    B_SH  = DIV_W + $clog2(TIMER_B_PERIOD);
    localparam logic [DIV_W:0] A_MUL = f_recip(TIMER_A_PERIOD, A_SH);
    localparam logic [DIV_W:0] B_MUL = f_recip(TIMER_B_PERIOD, B_SH);

    logic [1:0]  w_act;
    logic        w_port;
    logic        w_isd;
    logic [7:0]  w_val;
    logic [15:0] w_clk;
    logic [7:0]  w_reg;
    logic [2:0]  w_ch;
    logic [2:0]  w_kch;

    logic [7:0]  r_addr [2];
    logic [1:0]  r_act;
    logic [15:0] r_clk;
    logic [2:0]  r_qc;
    logic [1:0]  r_qo;
    logic [9:0]  r_rel_a, r_cnt_a;
    logic [7:0]  r_rel_b, r_cnt_b;
    logic [DIV_W-1:0] r_pre_a, r_pre_b;
    logic        r_run_a, r_run_b, r_en_a, r_en_b, r_csm_mode, r_csm_flag, r_irq;
    logic [1:0]  r_status;
    logic [10:0] r_fnum [CHANNELS];
    logic [2:0]  r_block [CHANNELS];
    logic [2:0]  r_hi [CHANNELS];
    logic [2:0]  r_blk_l [CHANNELS];
    logic [2:0]  r_alg [CHANNELS];
    logic [6:0]  r_tl [CHANNELS][OPERATORS];
    logic        r_keyed [CHANNELS][OPERATORS];

    logic [DIV_W-1:0] r_dvd, r_dvs, r_rem;
    logic [CNT_W-1:0] r_dcnt;
    logic             r_recip;
    logic [DIV_W:0]   w_trial;
    logic             w_ge;
    logic [DIV_W-1:0] w_rem_nx;

    logic [2*DIV_W:0]  w_qprod;
    logic [DIV_W-1:0]  w_quot;
    logic [15:0]       w_per;
    logic [DIV_W+15:0] w_pprod;

    logic             w_run;
    logic [10:0]      w_limit, w_cnt, w_first;
    logic [DIV_W-1:0] w_sum;

    logic             r_m_valid;
    logic [TDATA_W-1:0] r_m_data;
    logic [28:0]      w_res;
    logic             w_rd;

    assign w_act  = i_tuser[1:0];
    assign w_port = i_tuser[2];
    assign w_isd  = i_tuser[3];
    assign w_val  = i_tdata[7:0];
    assign w_clk  = i_tdata[23:8];
    assign w_reg  = r_addr[w_port];
    assign w_ch   = {1'b0, w_reg[1:0]} + (w_port ? 3'd3 : 3'd0);
    assign w_kch  = {1'b0, w_val[1:0]} + (w_val[2] ? 3'd3 : 3'd0);

    assign w_trial  = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge     = w_trial >= {1'b0, r_dvs};
    assign w_rem_nx = w_ge ? DIV_W'(w_trial - {1'b0, r_dvs}) : w_trial[DIV_W-1:0];

    assign w_qprod = (2*DIV_W+1)'(r_dvd) * (2*DIV_W+1)'(i_cmd.sel ? B_MUL : A_MUL);
    assign w_quot  = i_cmd.sel ? DIV_W'(w_qprod >> B_SH) : DIV_W'(w_qprod >> A_SH);
    assign w_per   = i_cmd.sel ? 16'(TIMER_B_PERIOD) : 16'(TIMER_A_PERIOD);
    assign w_pprod = (DIV_W+16)'(r_dvd) * (DIV_W+16)'(w_per);

    assign w_run   = i_cmd.sel ? r_run_b : r_run_a;
    assign w_limit = i_cmd.sel ? (11'd256 - {3'd0, r_rel_b}) : (11'd1024 - {1'b0, r_rel_a});
    assign w_cnt   = i_cmd.sel ? {3'd0, r_cnt_b} : {1'b0, r_cnt_a};
    assign w_first = (w_cnt < w_limit) ? (w_limit - w_cnt) : 11'd1;
    assign w_sum   = (i_cmd.sel ? r_pre_b : r_pre_a) + {1'b0, r_clk};

    assign o_sts.is_clock = (w_act == ACT_CLOCK);
    assign o_sts.div_done = (r_dcnt == '0);
    assign o_sts.need_mod = w_run && (r_dvd >= {6'd0, w_first});
    assign o_sts.out_free = !r_m_valid || i_m_ready;

    assign w_rd  = (r_act == ACT_READ) && (r_qc < 3'(CHANNELS));
    assign w_res = {r_csm_flag,
                    w_rd ? r_keyed[r_qc][r_qo] : 1'b0,
                    w_rd ? r_tl[r_qc][r_qo] : 7'd0,
                    w_rd ? r_alg[r_qc] : 3'd0,
                    w_rd ? r_block[r_qc] : 3'd0,
                    w_rd ? r_fnum[r_qc] : 11'd0,
                    r_status, r_irq};

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_m_data  <= '0;
        end else if (i_cmd.finish) begin
            r_m_valid <= 1'b1;
            r_m_data  <= {3'd0, w_res};
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvd   <= '0;
            r_dvs   <= '0;
            r_rem   <= '0;
            r_dcnt  <= '0;
            r_recip <= 1'b0;
        end else if (i_cmd.start_pre) begin
            r_dvd   <= w_sum;
            r_rem   <= '0;
            r_dcnt  <= CNT_W'(2);
            r_recip <= 1'b1;
        end else if (i_cmd.end_pre && o_sts.need_mod) begin
            r_dvd   <= r_dvd - {6'd0, w_first};
            r_dvs   <= {6'd0, w_limit};
            r_rem   <= '0;
            r_dcnt  <= CNT_W'(DIV_W);
            r_recip <= 1'b0;
        end else if (i_cmd.step && r_recip) begin
            if (r_dcnt == CNT_W'(2)) begin
                r_dvd <= w_quot;
                r_rem <= r_dvd;
            end else begin
                r_rem <= r_rem - w_pprod[DIV_W-1:0];
            end
            r_dcnt <= r_dcnt - 1'b1;
        end else if (i_cmd.step) begin
            r_dvd  <= {r_dvd[DIV_W-2:0], w_ge};
            r_rem  <= w_rem_nx;
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '{default: '0};
            r_act      <= ACT_WRITE;
            r_clk      <= '0;
            r_qc       <= '0;
            r_qo       <= '0;
            r_rel_a    <= '0;
            r_rel_b    <= '0;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_pre_a    <= '0;
            r_pre_b    <= '0;
            r_run_a    <= 1'b0;
            r_run_b    <= 1'b0;
            r_en_a     <= 1'b0;
            r_en_b     <= 1'b0;
            r_csm_mode <= 1'b0;
            r_csm_flag <= 1'b0;
            r_irq      <= 1'b0;
            r_status   <= '0;
            r_fnum     <= '{default: '0};
            r_block    <= '{default: '0};
            r_hi       <= '{default: '0};
            r_blk_l    <= '{default: '0};
            r_alg      <= '{default: '0};
            r_tl       <= '{default: '{default: '0}};
            r_keyed    <= '{default: '{default: 1'b0}};
        end else begin
            if (i_cmd.accept) begin
                r_act <= w_act;
                r_clk <= w_clk;
                r_qc  <= i_tdata[26:24];
                r_qo  <= i_tdata[28:27];
                r_irq <= 1'b0;
                if (w_act == ACT_WRITE && !w_isd) begin
                    r_addr[w_port] <= w_val;
                end else if (w_act == ACT_WRITE && w_reg < REG_OP_BASE) begin
                    if (!w_port) begin
                        case (w_reg)
                            REG_TA_HI: r_rel_a[9:2] <= w_val;
                            REG_TA_LO: r_rel_a[1:0] <= w_val[1:0];
                            REG_TB:    r_rel_b      <= w_val;
                            REG_TCTRL: begin
                                r_csm_mode <= w_val[7];
                                r_run_a    <= w_val[0];
                                r_run_b    <= w_val[1];
                                r_en_a     <= w_val[2];
                                r_en_b     <= w_val[3];
                                if (w_val[4]) r_status[0] <= 1'b0;
                                if (w_val[5]) r_status[1] <= 1'b0;
                            end
                            REG_KEY: begin
                                if (w_val[1:0] != CH_NONE) begin
                                    for (int i = 0; i < OPERATORS; i++) begin
                                        r_keyed[w_kch][C_SLOT[i]] <= w_val[4+i];
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end else if (w_act == ACT_WRITE && w_reg[1:0] != CH_NONE) begin
                    if (w_reg < REG_CH_BASE) begin
                        if (w_reg[7:4] == GRP_TL) begin
                            r_tl[w_ch][C_SLOT[w_reg[3:2]]] <= w_val[6:0];
                        end
                    end else begin
                        case ({w_reg[7:2], 2'b00})
                            REG_FNUM_LO: begin
                                r_fnum[w_ch]  <= {r_hi[w_ch], w_val};
                                r_block[w_ch] <= r_blk_l[w_ch];
                            end
                            REG_FNUM_HI: begin
                                r_hi[w_ch]    <= w_val[2:0];
                                r_blk_l[w_ch] <= w_val[5:3];
                            end
                            REG_ALG: r_alg[w_ch] <= w_val[2:0];
                            default: ;
                        endcase
                    end
                end
            end
            if (i_cmd.end_pre) begin
                if (i_cmd.sel) r_pre_b <= r_rem;
                else           r_pre_a <= r_rem;
                if (w_run && r_dvd != '0 && !o_sts.need_mod) begin
                    if (i_cmd.sel) r_cnt_b <= r_cnt_b + r_dvd[7:0];
                    else           r_cnt_a <= r_cnt_a + r_dvd[9:0];
                end
            end
            if (i_cmd.end_mod) begin
                if (i_cmd.sel) begin
                    r_cnt_b <= r_rem[7:0];
                    if (r_en_b) begin
                        r_status[1] <= 1'b1;
                        r_irq       <= 1'b1;
                    end
                end else begin
                    r_cnt_a <= r_rem[9:0];
                    if (r_csm_mode) begin
                        for (int i = 0; i < OPERATORS; i++) begin
                            r_keyed[2][i] <= 1'b1;
                        end
                        r_csm_flag <= 1'b1;
                    end
                    if (r_en_a) begin
                        r_status[0] <= 1'b1;
                        r_irq       <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

// File: design/fm_synth_register_and_timer_block.sv
// Top level of the FM register and timer block: sequencer plus datapath.
// Depends on fmsrt_pkg, fmsrt_ctrl, fmsrt_dp.
//
//  channel | direction | tdata (low bit up)                              | tuser
//  s_axis  | in        | value, clock_count, query_channel, query_op     | action, port, is_data
//  m_axis  | out       | irq, status, ch_fnum, ch_block, ch_algorithm,   | -
//          |           | op_total_level, op_keyed, csm_pending           |
//
// Write and read items go straight to the result; a clock item runs, for each timer, a
// reciprocal-multiply prescaler step, and each timer that wraps adds a one-bit-per-cycle
// modulo pass through the shared divider.
// One item is in work at a time; the next is taken while the result waits.
// Synchronous active-low reset clears all registers; m_axis stalls hold the result.
`timescale 1ns / 1ps
module fm_synth_register_and_timer_block import fmsrt_pkg::*; #(
    parameter int unsigned TIMER_A_PERIOD = C_TIMER_A_PERIOD,
    parameter int unsigned TIMER_B_PERIOD = C_TIMER_B_PERIOD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,  // value, clock_count, query_channel, query_operator
    input  logic [TUSER_W-1:0] i_s_axis_tuser,  // action, port, is_data
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata   // irq, status, ch_fnum, ch_block, ch_algorithm,
                                                // op_total_level, op_keyed, csm_pending
);
    t_cmd w_cmd;
    t_sts w_sts;

    fmsrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fmsrt_dp #(
        .TIMER_A_PERIOD (TIMER_A_PERIOD),
        .TIMER_B_PERIOD (TIMER_B_PERIOD)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_tuser   (i_s_axis_tuser),
        .i_tdata   (i_s_axis_tdata),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata)
    );

    assign o_s_axis_tready = w_cmd.idle;

endmodule

// File: design/fmsrt_checker.sv
// Port-level checks of the FM register and timer block, bound to the top level.
// Depends on fmsrt_pkg and fm_synth_register_and_timer_block_macros.svh.
`timescale 1ns / 1ps
`include "fm_synth_register_and_timer_block_macros.svh"
module fmsrt_checker import fmsrt_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic [TDATA_W-1:0] i_s_axis_tdata,
    input logic [TUSER_W-1:0] i_s_axis_tuser,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [TDATA_W-1:0] o_m_axis_tdata
);
    `FMS_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `FMS_ASSERT_NEXT(a_busy, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `FMS_ASSERT_SAME(a_irq_sts, o_m_axis_tvalid && o_m_axis_tdata[0], o_m_axis_tdata[2:1] != 2'd0)
    `FMS_ASSERT_SAME(a_irq_nord, o_m_axis_tvalid && o_m_axis_tdata[0], o_m_axis_tdata[27:3] == 25'd0)
endmodule

bind fm_synth_register_and_timer_block fmsrt_checker u_chk (.*);
